### rtl/nvs_pkg.sv
// Shared constants and types for the nearest vertex search unit.
package nvs_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int ADDRESSABLE  = 64;
  localparam int SCAN_LIMIT   = (MAX_VERTICES < ADDRESSABLE) ? MAX_VERTICES : ADDRESSABLE;
  localparam int RAM_AW       = $clog2(MAX_VERTICES);
  localparam int SCAN_W       = $clog2(SCAN_LIMIT);

  localparam int COORD_W = 16;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 1;
  localparam int VERT_W  = 2 * COORD_W;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [INDEX_W-1:0] index_t;
  typedef logic        [COUNT_W-1:0] count_t;
  typedef logic        [DIST_W-1:0]  dist_t;

  localparam count_t SCAN_LIMIT_C = COUNT_W'(SCAN_LIMIT);

endpackage

### rtl/nvs_in_if.sv
// Input channel: vertex writes and queries.
interface nvs_in_if
  import nvs_pkg::*;
  ();
  logic   valid;
  logic   ready;
  cmd_t   command;
  index_t entry_index;
  coord_t coord_x;
  coord_t coord_y;

  modport source (output valid, command, entry_index, coord_x, coord_y, input ready);
  modport sink   (input valid, command, entry_index, coord_x, coord_y, output ready);
endinterface

### rtl/nvs_out_if.sv
// Result channel: nearest vertex index and squared distance.
interface nvs_out_if
  import nvs_pkg::*;
  ();
  logic   valid;
  logic   ready;
  index_t nearest_index;
  dist_t  nearest_dist_sq;

  modport source (output valid, nearest_index, nearest_dist_sq, input ready);
  modport sink   (input valid, nearest_index, nearest_dist_sq, output ready);
endinterface

### rtl/nvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/nearest_vertex_search_unit.sv
// Nearest vertex search: vertex table in RAM, linear scan per query.
//
//   channel  dir  word                                          handshake
//   in_ch    in   command, entry_index, coord_x, coord_y        valid/ready
//   out_ch   out  nearest_index, nearest_dist_sq                valid/ready
//   cfg_*    in   vertex_count (7 bits)                         write enable
//
// A write word lands in the table RAM at acceptance.
// A query reads its N scanned entries, one RAM read per cycle, and passes
// them through four stages (difference, square, sum, compare) and a result load.
// in_ch.ready is low from query acceptance until its result is loaded.
// A result waits in the output register; a following write word still goes in.
// Reset (rst_n low, synchronous) sets vertex_count to 1; the table is not cleared.
module nearest_vertex_search_unit
  import nvs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  nvs_in_if.sink            in_ch,
  nvs_out_if.source         out_ch,
  input  logic              cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state_r;

  count_t              vertex_count_r;
  logic                in_acc;
  logic                ram_we;
  logic [RAM_AW-1:0]   ram_wr_addr;
  logic                ram_re;
  logic [VERT_W-1:0]   ram_rd_data;

  coord_t              qx_r, qy_r;
  logic [SCAN_W-1:0]   rd_idx_r, last_r;
  count_t              count_clamped;
  logic [SCAN_W-1:0]   last_nxt;

  // pipeline
  logic                p0_vld_r, p0_last_r;
  logic [SCAN_W-1:0]   p0_idx_r;
  logic                s1_vld_r, s1_last_r;
  logic [SCAN_W-1:0]   s1_idx_r;
  logic [COORD_W-1:0]  s1_mx_r, s1_my_r;
  logic                s2_vld_r, s2_last_r;
  logic [SCAN_W-1:0]   s2_idx_r;
  logic [SQ_W-1:0]     s2_sqx_r, s2_sqy_r;
  logic                s3_vld_r, s3_last_r;
  logic [SCAN_W-1:0]   s3_idx_r;
  dist_t               s3_sum_r;
  dist_t               best_d_r;
  logic [SCAN_W-1:0]   best_idx_r;

  coord_t              vx, vy;
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]    ndx, ndy;

  logic                out_valid_r;
  index_t              out_idx_r;
  dist_t               out_dist_r;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign ram_we      = in_acc && (in_ch.command == CMD_WRITE)
                       && (int'(in_ch.entry_index) < MAX_VERTICES);
  assign ram_wr_addr = RAM_AW'(in_ch.entry_index);
  assign ram_re      = (state_r == ST_SCAN);

  nvs_ram #(
    .WIDTH(VERT_W),
    .DEPTH(MAX_VERTICES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data ({in_ch.coord_x, in_ch.coord_y}),
    .rd_en   (ram_re),
    .rd_addr (RAM_AW'(rd_idx_r)),
    .rd_data (ram_rd_data)
  );

  // zero count scans entry 0; large counts saturate at the addressable limit
  always_comb begin
    if (vertex_count_r == '0) begin
      count_clamped = COUNT_W'(1);
    end else if (vertex_count_r > SCAN_LIMIT_C) begin
      count_clamped = SCAN_LIMIT_C;
    end else begin
      count_clamped = vertex_count_r;
    end
    last_nxt = SCAN_W'(count_clamped - COUNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= COUNT_W'(1);
    end else if (cfg_wr_en) begin
      vertex_count_r <= cfg_wr_data;
    end
  end

  // control FSM and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // ST_FINISH does its own handoff of the output register
      if (out_valid_r && out_ch.ready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_ch.command == CMD_QUERY)) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_idx_r == last_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (s3_vld_r && s3_last_r) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= INDEX_W'(best_idx_r);
            out_dist_r  <= best_d_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // scan address and query latch
  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.command == CMD_QUERY)) begin
      qx_r     <= in_ch.coord_x;
      qy_r     <= in_ch.coord_y;
      rd_idx_r <= '0;
      last_r   <= last_nxt;
    end else if (ram_re) begin
      rd_idx_r <= rd_idx_r + SCAN_W'(1);
    end
  end

  assign vx  = ram_rd_data[VERT_W-1:COORD_W];
  assign vy  = ram_rd_data[COORD_W-1:0];
  assign dx  = {qx_r[COORD_W-1], qx_r} - {vx[COORD_W-1], vx};
  assign dy  = {qy_r[COORD_W-1], qy_r} - {vy[COORD_W-1], vy};
  assign ndx = -dx;
  assign ndy = -dy;

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      p0_vld_r <= ram_re;
      s1_vld_r <= p0_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // pipeline payload and running minimum
  always_ff @(posedge clk) begin
    p0_idx_r  <= rd_idx_r;
    p0_last_r <= (rd_idx_r == last_r);

    // magnitude of a 17-bit difference fits in 16 bits
    s1_idx_r  <= p0_idx_r;
    s1_last_r <= p0_last_r;
    s1_mx_r   <= dx[COORD_W] ? COORD_W'(ndx) : COORD_W'(dx);
    s1_my_r   <= dy[COORD_W] ? COORD_W'(ndy) : COORD_W'(dy);

    s2_idx_r  <= s1_idx_r;
    s2_last_r <= s1_last_r;
    s2_sqx_r  <= s1_mx_r * s1_mx_r;
    s2_sqy_r  <= s1_my_r * s1_my_r;

    s3_idx_r  <= s2_idx_r;
    s3_last_r <= s2_last_r;
    s3_sum_r  <= DIST_W'(s2_sqx_r) + DIST_W'(s2_sqy_r);

    // strict less keeps the lowest index on ties
    if (s3_vld_r && ((s3_idx_r == '0) || (s3_sum_r < best_d_r))) begin
      best_d_r   <= s3_sum_r;
      best_idx_r <= s3_idx_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.nearest_index   = out_idx_r;
  assign out_ch.nearest_dist_sq = out_dist_r;

  a_accept_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!p0_vld_r && !s1_vld_r && !s2_vld_r && !s3_vld_r))
    else $error("word accepted while scan pipeline busy");

  a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE))
    else $error("table write outside idle");

  a_last_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_vld_r && s3_last_r) |=> (state_r == ST_FINISH))
    else $error("scan end did not reach finish");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> (best_idx_r <= last_r))
    else $error("nearest index beyond scanned range");

  a_scan_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rd_idx_r <= last_r))
    else $error("scan address past last entry");

endmodule
